// ===== rtl/aekd_pkg.sv =====
// Package for the ANSI escape key decoder.
// Holds sizes, byte codes, result kinds and the command word passed from front to back.
// Depends on nothing.
`default_nettype none

package aekd_pkg;

   localparam int BUF_DEPTH = 16;
   localparam int IDX_W     = $clog2(BUF_DEPTH);
   localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

   localparam int Q_DEPTH   = 2;
   localparam int QPTR_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int QCNT_W    = $clog2(Q_DEPTH + 1);

   localparam logic [7:0]  ESC_BYTE      = 8'h1B;
   localparam logic [7:0]  NUL_BYTE      = 8'h00;
   localparam logic [7:0]  CHAR_SS3      = 8'h4F;
   localparam logic [7:0]  CHAR_CSI      = 8'h5B;
   localparam logic [7:0]  PF_LO         = 8'h50;
   localparam logic [7:0]  PF_HI         = 8'h53;
   localparam logic [7:0]  PARAM_LO      = 8'h30;
   localparam logic [7:0]  PARAM_HI      = 8'h3F;
   localparam logic [7:0]  INTER_LO      = 8'h20;
   localparam logic [7:0]  INTER_HI      = 8'h2E;
   localparam logic [7:0]  FINAL_LO      = 8'h40;
   localparam logic [7:0]  FINAL_HI      = 8'h7E;
   localparam logic [7:0]  DIGIT_LO      = 8'h30;
   localparam logic [7:0]  DIGIT_HI      = 8'h39;
   localparam logic [31:0] PF_BASE       = 32'h5046_4F00;
   localparam logic [31:0] CSI_NUM_BASE  = 32'h005B_0000;

   typedef enum logic [1:0] {
      KIND_PLAIN = 2'd0,
      KIND_CSI   = 2'd1,
      KIND_PF    = 2'd2,
      KIND_RAW   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_EMIT  = 2'd1,
      OP_FLUSH = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_PREFIX = 3'd1,
      PH_PF     = 3'd2,
      PH_PARAM  = 3'd3,
      PH_INTER  = 3'd4
   } phase_type;

   typedef enum logic [0:0] {
      BK_IDLE  = 1'b0,
      BK_DRAIN = 1'b1
   } back_state_type;

   typedef struct packed {
      logic        push;
      logic        clear;
      logic [7:0]  data;
      op_type      op;
      logic [31:0] code;
      kind_type    kind;
   } cmd_type;

endpackage

`default_nettype wire

// ===== rtl/aekd_if.sv =====
// Channel interfaces of the ANSI escape key decoder.
// Request channel carries received words, response channel carries key results.
// Depends on nothing.
`default_nettype none

interface aekd_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] rx_byte;
   modport source (output valid, mode, rx_byte, input ready);
   modport sink   (input valid, mode, rx_byte, output ready);
endinterface

interface aekd_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] key_code;
   logic [1:0]  key_kind;
   logic        last;
   modport source (output valid, key_code, key_kind, last, input ready);
   modport sink   (input valid, key_code, key_kind, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/aekd_front.sv =====
// Front end of the ANSI escape key decoder: accepts request words, tracks the parse phase.
// Emits at most one command word per accepted request into the command queue.
// Depends on aekd_pkg and aekd_req_if.
`default_nettype none

module aekd_front (
   input  wire logic            clock,
   input  wire logic            reset,
   aekd_req_if.sink             req_bus,
   input  wire logic            q_full,
   output aekd_pkg::cmd_type    cmd,
   output logic                 cmd_valid
);

   aekd_pkg::phase_type            phase_ff, phase_in;
   logic [aekd_pkg::CNT_W-1:0]     count_ff, count_in;
   logic                           in_digits_ff, in_digits_in;
   logic                           have_digits_ff, have_digits_in;
   logic [31:0]                    num_ff, num_in;
   logic [7:0]                     term_ff, term_in;

   logic        accept;
   logic        push_ok;
   logic [7:0]  b;
   logic        is_param, is_inter, is_final, is_digit, is_pf;
   logic [31:0] num_next;
   logic [7:0]  term_eff;
   logic [31:0] csi_code;

   assign req_bus.ready = !q_full;
   assign accept   = req_bus.valid && req_bus.ready;
   assign b        = req_bus.rx_byte;
   assign push_ok  = count_ff < aekd_pkg::CNT_W'(aekd_pkg::BUF_DEPTH);
   assign is_param = (b >= aekd_pkg::PARAM_LO) && (b <= aekd_pkg::PARAM_HI);
   assign is_inter = (b >= aekd_pkg::INTER_LO) && (b <= aekd_pkg::INTER_HI);
   assign is_final = (b >= aekd_pkg::FINAL_LO) && (b <= aekd_pkg::FINAL_HI);
   assign is_digit = (b >= aekd_pkg::DIGIT_LO) && (b <= aekd_pkg::DIGIT_HI);
   assign is_pf    = (b >= aekd_pkg::PF_LO) && (b <= aekd_pkg::PF_HI);
   assign num_next = (num_ff << 3) + (num_ff << 1) + {28'd0, b[3:0]};
   assign term_eff = (push_ok && in_digits_ff) ? b : term_ff;
   assign csi_code = have_digits_ff
                   ? ((aekd_pkg::CSI_NUM_BASE + (num_ff << 8)) | {24'd0, term_eff})
                   : {16'd0, aekd_pkg::CHAR_CSI, term_eff};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= aekd_pkg::PH_IDLE;
         count_ff       <= '0;
         in_digits_ff   <= 1'b0;
         have_digits_ff <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         count_ff       <= count_in;
         in_digits_ff   <= in_digits_in;
         have_digits_ff <= have_digits_in;
      end
      num_ff  <= num_in;
      term_ff <= term_in;
   end

   always_comb begin
      phase_in       = phase_ff;
      count_in       = count_ff;
      in_digits_in   = in_digits_ff;
      have_digits_in = have_digits_ff;
      num_in         = num_ff;
      term_in        = term_ff;
      cmd_valid      = 1'b0;
      cmd.push       = 1'b0;
      cmd.clear      = 1'b0;
      cmd.data       = b;
      cmd.op         = aekd_pkg::OP_NONE;
      cmd.code       = {24'd0, b};
      cmd.kind       = aekd_pkg::KIND_PLAIN;
      if (accept) begin
         if (req_bus.mode) begin
            if (phase_ff != aekd_pkg::PH_IDLE) begin
               cmd_valid = 1'b1;
               cmd.op    = aekd_pkg::OP_FLUSH;
               phase_in  = aekd_pkg::PH_IDLE;
               count_in  = '0;
            end
         end else if (b != aekd_pkg::NUL_BYTE) begin
            unique case (phase_ff) inside
               aekd_pkg::PH_IDLE: begin
                  cmd_valid = 1'b1;
                  if (b == aekd_pkg::ESC_BYTE) begin
                     cmd.push       = 1'b1;
                     cmd.clear      = 1'b1;
                     count_in       = aekd_pkg::CNT_W'(1);
                     phase_in       = aekd_pkg::PH_PREFIX;
                     in_digits_in   = 1'b1;
                     have_digits_in = 1'b0;
                     num_in         = '0;
                     term_in        = '0;
                  end else begin
                     cmd.op = aekd_pkg::OP_EMIT;
                  end
               end
               aekd_pkg::PH_PREFIX: begin
                  cmd_valid = 1'b1;
                  cmd.push  = push_ok;
                  count_in  = count_ff + aekd_pkg::CNT_W'(push_ok);
                  if (b == aekd_pkg::CHAR_SS3) begin
                     phase_in = aekd_pkg::PH_PF;
                  end else if (b == aekd_pkg::CHAR_CSI) begin
                     phase_in = aekd_pkg::PH_PARAM;
                  end else begin
                     cmd.op   = aekd_pkg::OP_FLUSH;
                     phase_in = aekd_pkg::PH_IDLE;
                     count_in = '0;
                  end
               end
               aekd_pkg::PH_PF: begin
                  cmd_valid = 1'b1;
                  phase_in  = aekd_pkg::PH_IDLE;
                  count_in  = '0;
                  if (is_pf) begin
                     cmd.op   = aekd_pkg::OP_EMIT;
                     cmd.code = aekd_pkg::PF_BASE | {24'd0, b};
                     cmd.kind = aekd_pkg::KIND_PF;
                  end else begin
                     cmd.push = push_ok;
                     cmd.op   = aekd_pkg::OP_FLUSH;
                  end
               end
               aekd_pkg::PH_PARAM, aekd_pkg::PH_INTER: begin
                  if (((phase_ff == aekd_pkg::PH_PARAM) && is_param) || is_inter) begin
                     cmd_valid = push_ok;
                     cmd.push  = push_ok;
                     count_in  = count_ff + aekd_pkg::CNT_W'(push_ok);
                     if (is_inter) begin
                        phase_in = aekd_pkg::PH_INTER;
                     end
                     if (push_ok && in_digits_ff) begin
                        if (is_digit) begin
                           num_in         = num_next;
                           have_digits_in = 1'b1;
                        end else begin
                           in_digits_in = 1'b0;
                           term_in      = b;
                        end
                     end
                  end else if (is_final) begin
                     cmd_valid = 1'b1;
                     cmd.op    = aekd_pkg::OP_EMIT;
                     cmd.code  = csi_code;
                     cmd.kind  = aekd_pkg::KIND_CSI;
                     phase_in  = aekd_pkg::PH_IDLE;
                     count_in  = '0;
                  end else begin
                     cmd_valid = 1'b1;
                     cmd.op    = aekd_pkg::OP_FLUSH;
                     phase_in  = aekd_pkg::PH_IDLE;
                     count_in  = '0;
                  end
               end
               default: begin
                  phase_in = aekd_pkg::PH_IDLE;
                  count_in = '0;
               end
            endcase
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= aekd_pkg::CNT_W'(aekd_pkg::BUF_DEPTH))
      else $error("sequence count past buffer depth");
   a_open_has_esc: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != aekd_pkg::PH_IDLE) |-> (count_ff != '0))
      else $error("open sequence with empty buffer");
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == aekd_pkg::PH_IDLE) |-> (count_ff == '0))
      else $error("idle parser with buffered words");
   a_cmd_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd_valid |-> accept)
      else $error("command without accepted word");

endmodule

`default_nettype wire

// ===== rtl/aekd_cmd_queue.sv =====
// Short command queue between the front end and the back end of the key decoder.
// Holds up to aekd_pkg::Q_DEPTH command words in arrival order.
// Depends on aekd_pkg.
`default_nettype none

module aekd_cmd_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  aekd_pkg::cmd_type     wr_data,
   output logic                  full,
   input  wire logic             rd_en,
   output logic                  rd_valid,
   output aekd_pkg::cmd_type     rd_data
);

   aekd_pkg::cmd_type              slots_ff [aekd_pkg::Q_DEPTH];
   logic [aekd_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [aekd_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [aekd_pkg::QCNT_W-1:0]    fill_ff, fill_in;
   logic                           do_wr, do_rd;

   assign full     = fill_ff == aekd_pkg::QCNT_W'(aekd_pkg::Q_DEPTH);
   assign rd_valid = fill_ff != '0;
   assign rd_data  = slots_ff[rd_ptr_ff];
   assign do_wr    = wr_en && !full;
   assign do_rd    = rd_en && rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == aekd_pkg::QPTR_W'(aekd_pkg::Q_DEPTH - 1))
                   ? '0 : wr_ptr_ff + aekd_pkg::QPTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == aekd_pkg::QPTR_W'(aekd_pkg::Q_DEPTH - 1))
                   ? '0 : rd_ptr_ff + aekd_pkg::QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         fill_in = fill_ff + aekd_pkg::QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
         fill_in = fill_ff - aekd_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_wr) begin
         slots_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !full)
      else $error("command queue overflow");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= aekd_pkg::QCNT_W'(aekd_pkg::Q_DEPTH))
      else $error("command queue fill past depth");
   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      (do_wr && !do_rd) |=> (fill_ff == $past(fill_ff) + aekd_pkg::QCNT_W'(1)))
      else $error("command queue fill not advanced on write");

endmodule

`default_nettype wire

// ===== rtl/aekd_back.sv =====
// Back end of the key decoder: runs commands, owns the sequence buffer and the result register.
// Drains buffered words as raw results on a failed sequence.
// Depends on aekd_pkg and aekd_rsp_if.
`default_nettype none

module aekd_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             cmd_valid,
   input  aekd_pkg::cmd_type     cmd,
   output logic                  cmd_pop,
   aekd_rsp_if.source            rsp_bus
);

   logic [7:0]                     seq_mem [aekd_pkg::BUF_DEPTH];
   logic [7:0]                     rd_data_ff;
   logic [aekd_pkg::IDX_W-1:0]     rd_addr;
   logic                           wr_en;
   logic [aekd_pkg::IDX_W-1:0]     wr_addr;

   aekd_pkg::back_state_type       state_ff, state_in;
   logic [aekd_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [aekd_pkg::CNT_W-1:0]     count_eff;
   logic [aekd_pkg::IDX_W-1:0]     idx_ff, idx_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [31:0]                    rsp_code_ff, rsp_code_in;
   aekd_pkg::kind_type             rsp_kind_ff, rsp_kind_in;
   logic                           rsp_last_ff, rsp_last_in;
   logic                           out_free;
   logic                           load;
   logic                           drain_last;

   assign out_free         = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.key_code = rsp_code_ff;
   assign rsp_bus.key_kind = rsp_kind_ff;
   assign rsp_bus.last     = rsp_last_ff;
   assign drain_last       = (aekd_pkg::CNT_W'(idx_ff) + aekd_pkg::CNT_W'(1)) == count_ff;
   assign wr_addr          = cmd.clear ? '0 : count_ff[aekd_pkg::IDX_W-1:0];
   assign count_eff        = cmd.clear ? aekd_pkg::CNT_W'(1)
                           : count_ff + aekd_pkg::CNT_W'(cmd.push);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         seq_mem[wr_addr] <= cmd.data;
      end
      rd_data_ff <= seq_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= aekd_pkg::BK_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_code_ff <= rsp_code_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      cmd_pop     = 1'b0;
      wr_en       = 1'b0;
      rd_addr     = idx_ff;
      load        = 1'b0;
      rsp_code_in = rsp_code_ff;
      rsp_kind_in = rsp_kind_ff;
      rsp_last_in = rsp_last_ff;
      unique case (state_ff)
         aekd_pkg::BK_IDLE: begin
            rd_addr = '0;
            if (cmd_valid && out_free) begin
               cmd_pop  = 1'b1;
               wr_en    = cmd.push;
               count_in = (cmd.push || cmd.clear) ? count_eff : count_ff;
               unique case (cmd.op)
                  aekd_pkg::OP_EMIT: begin
                     load        = 1'b1;
                     rsp_code_in = cmd.code;
                     rsp_kind_in = cmd.kind;
                     rsp_last_in = 1'b1;
                     count_in    = '0;
                  end
                  aekd_pkg::OP_FLUSH: begin
                     idx_in = '0;
                     if (count_eff != '0) begin
                        state_in = aekd_pkg::BK_DRAIN;
                        count_in = count_eff;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         aekd_pkg::BK_DRAIN: begin
            if (out_free) begin
               load        = 1'b1;
               rsp_code_in = {24'd0, rd_data_ff};
               rsp_kind_in = aekd_pkg::KIND_RAW;
               rsp_last_in = drain_last;
               rd_addr     = idx_ff + aekd_pkg::IDX_W'(1);
               if (drain_last) begin
                  state_in = aekd_pkg::BK_IDLE;
                  count_in = '0;
               end else begin
                  idx_in = idx_ff + aekd_pkg::IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = aekd_pkg::BK_IDLE;
         end
      endcase
      rsp_valid_in = load ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);
   end

   a_drain_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == aekd_pkg::BK_DRAIN) |-> (aekd_pkg::CNT_W'(idx_ff) < count_ff))
      else $error("drain index past buffered count");
   a_no_pop_in_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == aekd_pkg::BK_DRAIN) |-> !cmd_pop)
      else $error("command taken while draining");
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |=> (rsp_valid_ff && $stable(rsp_code_ff)))
      else $error("stalled result changed");
   a_drain_ends_last: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == aekd_pkg::BK_DRAIN) && out_free && drain_last)
      |=> (rsp_last_ff && state_ff == aekd_pkg::BK_IDLE))
      else $error("drain end without last flag");

endmodule

`default_nettype wire

// ===== rtl/ansi_escape_key_decoder.sv =====
// Top level of the ANSI escape key decoder.
// Connects the front end, the command queue and the back end.
// Depends on aekd_pkg, aekd_if, aekd_front, aekd_cmd_queue and aekd_back.
`default_nettype none

// Turns terminal bytes and gap timeouts into key codes. The front end takes one request
// word per cycle while the two-entry command queue has room, and a word that ends a
// sequence or a plain key leaves one result. A failed or timed-out sequence of n buffered
// bytes leaves n raw results, one per cycle while the receiver takes them, since the
// back end reads the sequence buffer through its single read port; n is at most
// aekd_pkg::BUF_DEPTH. After taking a flush the back end takes no new command until
// the drain ends. The buffer needs no clearing pass after reset.
module ansi_escape_key_decoder (
   input  wire logic   clock,
   input  wire logic   reset,
   aekd_req_if.sink    req_bus,
   aekd_rsp_if.source  rsp_bus
);

   aekd_pkg::cmd_type  front_cmd;
   logic               front_cmd_valid;
   logic               q_full;
   aekd_pkg::cmd_type  back_cmd;
   logic               back_cmd_valid;
   logic               back_cmd_pop;

   aekd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .q_full    (q_full),
      .cmd       (front_cmd),
      .cmd_valid (front_cmd_valid)
   );

   aekd_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (front_cmd_valid),
      .wr_data  (front_cmd),
      .full     (q_full),
      .rd_en    (back_cmd_pop),
      .rd_valid (back_cmd_valid),
      .rd_data  (back_cmd)
   );

   aekd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (back_cmd_valid),
      .cmd       (back_cmd),
      .cmd_pop   (back_cmd_pop),
      .rsp_bus   (rsp_bus)
   );

endmodule

`default_nettype wire

// ===== dv/tb_ansi_escape_key_decoder.sv =====
// Self-checking testbench for ansi_escape_key_decoder: directed table, then random bursts.
// A behavioral decoder predicts key results the table does not give; the response stream is checked in order.
// Depends on aekd_pkg, aekd_if and the ansi_escape_key_decoder RTL.
`timescale 1ns / 1ps

module tb_ansi_escape_key_decoder;

   localparam logic MODE_BYTE    = 1'b0;
   localparam logic MODE_GAP     = 1'b1;
   localparam int   RANDOM_WORDS = 185;
   localparam int   DRAIN_CYCLES = 2 * aekd_pkg::BUF_DEPTH + 16;
   localparam int   CYCLE_LIMIT  = 400000;

   typedef struct packed {
      logic [31:0]        code;
      aekd_pkg::kind_type kind;
      logic               last;
   } key_result_type;

   typedef struct packed {
      logic               mode;
      logic [7:0]         rx;
      logic               typed;
      logic [31:0]        code;
      aekd_pkg::kind_type kind;
   } stim_row_type;

   localparam stim_row_type DIRECTED [26] = '{
      '{MODE_BYTE, 8'h41,              1'b1, 32'h0000_0041, aekd_pkg::KIND_PLAIN},
      '{MODE_BYTE, 8'hFF,              1'b1, 32'h0000_00FF, aekd_pkg::KIND_PLAIN},
      '{MODE_GAP,  8'h00,              1'b0, 32'h0,         aekd_pkg::KIND_PLAIN},
      '{MODE_BYTE, aekd_pkg::ESC_BYTE, 1'b0, 32'h0,         aekd_pkg::KIND_PLAIN},
      '{MODE_BYTE, aekd_pkg::NUL_BYTE, 1'b0, 32'h0,         aekd_pkg::KIND_PLAIN},
      '{MODE_BYTE, aekd_pkg::CHAR_SS3, 1'b0, 32'h0,         aekd_pkg::KIND_PLAIN},
      '{MODE_BYTE, aekd_pkg::PF_HI,    1'b1, 32'h5046_4F53, aekd_pkg::KIND_PF},
      '{MODE_BYTE, aekd_pkg::ESC_BYTE, 1'b0, 32'h0,         aekd_pkg::KIND_PLAIN},
      '{MODE_BYTE, aekd_pkg::CHAR_SS3, 1'b0, 32'h0,         aekd_pkg::KIND_PLAIN},
      '{MODE_BYTE, 8'h54,              1'b0, 32'h0,         aekd_pkg::KIND_PLAIN},
      '{MODE_BYTE, aekd_pkg::ESC_BYTE, 1'b0, 32'h0,         aekd_pkg::KIND_PLAIN},
      '{MODE_BYTE, 8'h7D,              1'b0, 32'h0,         aekd_pkg::KIND_PLAIN},
      '{MODE_BYTE, aekd_pkg::ESC_BYTE, 1'b0, 32'h0,         aekd_pkg::KIND_PLAIN},
      '{MODE_BYTE, aekd_pkg::CHAR_CSI, 1'b0, 32'h0,         aekd_pkg::KIND_PLAIN},
      '{MODE_BYTE, 8'h31,              1'b0, 32'h0,         aekd_pkg::KIND_PLAIN},
      '{MODE_BYTE, aekd_pkg::INTER_LO, 1'b0, 32'h0,         aekd_pkg::KIND_PLAIN},
      '{MODE_BYTE, 8'h35,              1'b0, 32'h0,         aekd_pkg::KIND_PLAIN},
      '{MODE_BYTE, aekd_pkg::ESC_BYTE, 1'b0, 32'h0,         aekd_pkg::KIND_PLAIN},
      '{MODE_BYTE, aekd_pkg::CHAR_CSI, 1'b0, 32'h0,         aekd_pkg::KIND_PLAIN},
      '{MODE_GAP,  8'hA5,              1'b0, 32'h0,         aekd_pkg::KIND_PLAIN},
      '{MODE_BYTE, aekd_pkg::ESC_BYTE, 1'b0, 32'h0,         aekd_pkg::KIND_PLAIN},
      '{MODE_BYTE, aekd_pkg::CHAR_CSI, 1'b0, 32'h0,         aekd_pkg::KIND_PLAIN},
      '{MODE_BYTE, aekd_pkg::FINAL_LO, 1'b1, 32'h0000_5B40, aekd_pkg::KIND_CSI},
      '{MODE_BYTE, aekd_pkg::ESC_BYTE, 1'b0, 32'h0,         aekd_pkg::KIND_PLAIN},
      '{MODE_BYTE, aekd_pkg::CHAR_CSI, 1'b0, 32'h0,         aekd_pkg::KIND_PLAIN},
      '{MODE_BYTE, aekd_pkg::FINAL_HI, 1'b1, 32'h0000_5B7E, aekd_pkg::KIND_CSI}
   };

   logic clock = 1'b0;
   logic reset;

   aekd_req_if req_bus ();
   aekd_rsp_if rsp_bus ();

   ansi_escape_key_decoder dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   logic [7:0]          seq_bytes [aekd_pkg::BUF_DEPTH];
   int unsigned         seq_len = 0;
   aekd_pkg::phase_type parse_state = aekd_pkg::PH_IDLE;
   key_result_type      step_keys [$];
   key_result_type      pending_keys [$];
   logic [8:0]          burst [$];
   int                  send_idle_pct = 14;
   int                  recv_idle_pct = 67;
   int                  errors = 0;
   int                  cycles = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void emit_key(input logic [31:0] code, input aekd_pkg::kind_type kind);
      step_keys.push_back('{code, kind, 1'b0});
   endfunction

   function automatic void store_byte(input logic [7:0] b);
      if (seq_len < aekd_pkg::BUF_DEPTH) begin
         seq_bytes[seq_len] = b;
         seq_len++;
      end
   endfunction

   function automatic void flush_seq();
      for (int unsigned i = 0; i < seq_len; i++) begin
         emit_key({24'h0, seq_bytes[i]}, aekd_pkg::KIND_RAW);
      end
      seq_len = 0;
      parse_state = aekd_pkg::PH_IDLE;
   endfunction

   function automatic void decode_word(input logic m, input logic [7:0] b);
      key_result_type tail;
      int unsigned    idx;
      logic [31:0]    num;
      logic [31:0]    acc;
      logic [31:0]    term;
      step_keys.delete();
      if (m == MODE_GAP) begin
         if (parse_state != aekd_pkg::PH_IDLE) flush_seq();
      end else if (b != aekd_pkg::NUL_BYTE) begin
         case (parse_state) inside
            aekd_pkg::PH_IDLE: begin
               if (b == aekd_pkg::ESC_BYTE) begin
                  seq_len = 0;
                  store_byte(b);
                  parse_state = aekd_pkg::PH_PREFIX;
               end else begin
                  emit_key({24'h0, b}, aekd_pkg::KIND_PLAIN);
               end
            end
            aekd_pkg::PH_PREFIX: begin
               store_byte(b);
               if (b == aekd_pkg::CHAR_SS3) parse_state = aekd_pkg::PH_PF;
               else if (b == aekd_pkg::CHAR_CSI) parse_state = aekd_pkg::PH_PARAM;
               else flush_seq();
            end
            aekd_pkg::PH_PF: begin
               if (b >= aekd_pkg::PF_LO && b <= aekd_pkg::PF_HI) begin
                  emit_key(aekd_pkg::PF_BASE | {24'h0, b}, aekd_pkg::KIND_PF);
                  seq_len = 0;
                  parse_state = aekd_pkg::PH_IDLE;
               end else begin
                  store_byte(b);
                  flush_seq();
               end
            end
            aekd_pkg::PH_PARAM, aekd_pkg::PH_INTER: begin
               if (parse_state == aekd_pkg::PH_PARAM &&
                   b >= aekd_pkg::PARAM_LO && b <= aekd_pkg::PARAM_HI) begin
                  store_byte(b);
               end else if (b >= aekd_pkg::INTER_LO && b <= aekd_pkg::INTER_HI) begin
                  store_byte(b);
                  parse_state = aekd_pkg::PH_INTER;
               end else if (b >= aekd_pkg::FINAL_LO && b <= aekd_pkg::FINAL_HI) begin
                  store_byte(b);
                  idx = 2;
                  num = 32'h0;
                  acc = {24'h0, aekd_pkg::CHAR_CSI};
                  term = 32'h0;
                  while (idx < seq_len && seq_bytes[idx] >= aekd_pkg::DIGIT_LO &&
                         seq_bytes[idx] <= aekd_pkg::DIGIT_HI) begin
                     num = num * 32'd10 + {24'h0, seq_bytes[idx] - aekd_pkg::DIGIT_LO};
                     idx++;
                  end
                  if (idx > 2) acc = (acc << 8) + num;
                  if (idx < seq_len) term = {24'h0, seq_bytes[idx]};
                  emit_key((acc << 8) + term, aekd_pkg::KIND_CSI);
                  seq_len = 0;
                  parse_state = aekd_pkg::PH_IDLE;
               end else begin
                  flush_seq();
               end
            end
            default: begin
               seq_len = 0;
               parse_state = aekd_pkg::PH_IDLE;
            end
         endcase
      end
      if (step_keys.size() != 0) begin
         tail = step_keys.pop_back();
         tail.last = 1'b1;
         step_keys.push_back(tail);
      end
   endfunction

   // occasionally slip a null word in ahead of the byte
   function automatic void add_byte(input logic [7:0] b);
      if ($urandom_range(0, 19) == 0) burst.push_back({MODE_BYTE, aekd_pkg::NUL_BYTE});
      burst.push_back({MODE_BYTE, b});
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ERROR %s", $time, what);
      errors++;
   endtask

   task automatic send_word(input stim_row_type row);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.mode    <= row.mode;
      req_bus.rx_byte <= row.rx;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      decode_word(row.mode, row.rx);
      if (row.typed) begin
         pending_keys.push_back('{row.code, row.kind, 1'b1});
      end else begin
         foreach (step_keys[i]) pending_keys.push_back(step_keys[i]);
      end
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("ansi_escape_key_decoder: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      key_result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_keys.size() == 0) begin
            report_mismatch($sformatf("unexpected key %h kind %0d",
                                      rsp_bus.key_code, rsp_bus.key_kind));
         end else begin
            want = pending_keys.pop_front();
            if (rsp_bus.key_code !== want.code)
               report_mismatch($sformatf("key_code %h, want %h", rsp_bus.key_code, want.code));
            if (rsp_bus.key_kind !== want.kind)
               report_mismatch($sformatf("key_kind %0d, want %0d for %h",
                                         rsp_bus.key_kind, want.kind, want.code));
            if (rsp_bus.last !== want.last)
               report_mismatch($sformatf("last %b, want %b for %h",
                                         rsp_bus.last, want.last, want.code));
         end
      end
   end

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   initial begin
      stim_row_type row;
      int           words;
      int           tier;
      int           cur_tier;
      int           pick;
      logic [7:0]   digit;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.mode = MODE_BYTE;
      req_bus.rx_byte = aekd_pkg::NUL_BYTE;
      words = 0;
      cur_tier = 0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIRECTED[i]) send_word(DIRECTED[i]);

      while (words < RANDOM_WORDS) begin
         tier = words * 3 / RANDOM_WORDS;
         if (tier != cur_tier) begin
            // hold off until every key is out, then change the idling
            req_bus.valid <= 1'b0;
            while (pending_keys.size() != 0) @(posedge clock);
            @(negedge clock);
            cur_tier = tier;
            send_idle_pct = (tier == 1) ? 67 : 0;
            recv_idle_pct = (tier == 1) ? 14 : 0;
         end

         burst.delete();
         pick = $urandom_range(0, 99);
         if (pick < 28) begin
            add_byte(8'($urandom_range(0, 255)));
         end else if (pick < 40) begin
            add_byte(aekd_pkg::ESC_BYTE);
            add_byte(aekd_pkg::CHAR_SS3);
            if ($urandom_range(0, 3) == 0) add_byte(8'($urandom_range(1, 255)));
            else add_byte(8'($urandom_range(aekd_pkg::PF_LO, aekd_pkg::PF_HI)));
         end else if (pick < 46) begin
            add_byte(aekd_pkg::ESC_BYTE);
            add_byte(8'($urandom_range(1, 255)));
            burst.push_back(9'($urandom_range(0, 511)));
         end else begin
            add_byte(aekd_pkg::ESC_BYTE);
            add_byte(aekd_pkg::CHAR_CSI);
            // mostly short numbers, now and then a long one that can fill the buffer
            repeat (($urandom_range(0, 7) == 0) ? $urandom_range(8, 18)
                                                : $urandom_range(0, 3)) begin
               digit = 8'(aekd_pkg::DIGIT_LO + $urandom_range(0, 9));
               add_byte(digit);
            end
            if ($urandom_range(0, 3) == 0) begin
               add_byte(8'($urandom_range(aekd_pkg::PARAM_LO, aekd_pkg::PARAM_HI)));
               add_byte(8'(aekd_pkg::DIGIT_LO + $urandom_range(0, 9)));
            end
            repeat ($urandom_range(0, 2))
               add_byte(8'($urandom_range(aekd_pkg::INTER_LO, aekd_pkg::INTER_HI)));
            pick = $urandom_range(0, 99);
            if (pick < 72) begin
               add_byte(8'($urandom_range(aekd_pkg::FINAL_LO, aekd_pkg::FINAL_HI)));
            end else if (pick < 82) begin
               burst.push_back({MODE_GAP, 8'($urandom_range(0, 255))});
            end else if (pick < 92) begin
               add_byte(8'($urandom_range(1, 255)));
            end else begin
               add_byte(8'($urandom_range(aekd_pkg::INTER_LO, aekd_pkg::INTER_HI)));
               add_byte(8'($urandom_range(aekd_pkg::PARAM_LO, aekd_pkg::PARAM_HI)));
            end
         end

         foreach (burst[k]) begin
            row.mode  = burst[k][8];
            row.rx    = burst[k][7:0];
            row.typed = 1'b0;
            row.code  = 32'h0;
            row.kind  = aekd_pkg::KIND_PLAIN;
            words++;
            send_word(row);
         end
      end

      req_bus.valid <= 1'b0;
      while (pending_keys.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("ansi_escape_key_decoder: match");
      end else begin
         $display("ansi_escape_key_decoder: mismatch");
      end
      $finish;
   end

endmodule
